// ===== design/esd_pkg.sv =====
`default_nettype none

package esd_pkg;

   // datapath operations selected by the control word
   typedef enum logic [2:0] {
      OP_MUL   = 3'd0,
      OP_REM   = 3'd1,
      OP_FIX   = 3'd2,
      OP_YEAR  = 3'd3,
      OP_MONTH = 3'd4,
      OP_DONE  = 3'd5
   } esd_op_type;

   // which time-of-day field a division step produces
   typedef enum logic [1:0] {
      DSEL_SEC  = 2'd0,
      DSEL_MIN  = 2'd1,
      DSEL_HOUR = 2'd2
   } esd_dsel_type;

   localparam int unsigned PC_W = 4;

   typedef struct packed {
      esd_op_type    op;
      esd_dsel_type  dsel;
      logic [PC_W-1:0] target;
   } esd_uword_type;

   localparam logic [11:0] EPOCH_YEAR    = 12'd1970;
   localparam logic [8:0]  DAYS_COMMON   = 9'd365;
   localparam logic [8:0]  DAYS_LEAP     = 9'd366;
   localparam logic [6:0]  SECS_PER_MIN  = 7'd60;
   localparam logic [6:0]  MINS_PER_HOUR = 7'd60;
   localparam logic [6:0]  HOURS_PER_DAY = 7'd24;
   // floor(2^32 / d): the quotient estimate is at most one below the true one
   localparam logic [31:0] RECIP_60      = 32'd71582788;
   localparam logic [31:0] RECIP_24      = 32'd178956970;
   // only century in 1970..2106 that is not a multiple of 400
   localparam logic [11:0] CENTURY_2100  = 12'd2100;
   localparam logic [3:0]  LAST_MONTH    = 4'd11;

   // leap rule over the reachable years: 2000 is a multiple of 400, 2100 is not
   function automatic logic esd_is_leap(input logic [11:0] year);
      return (year[1:0] == 2'b00) && (year != CENTURY_2100);
   endfunction

   function automatic logic [4:0] esd_month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      unique case (month)
         4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
         4'd3, 4'd5, 4'd8, 4'd10:                  len = 5'd30;
         4'd1:                                     len = leap ? 5'd29 : 5'd28;
         default:                                  len = 5'd31;
      endcase
      return len;
   endfunction

   function automatic logic [6:0] esd_divisor(input esd_dsel_type dsel);
      logic [6:0] d;
      unique case (dsel)
         DSEL_SEC:  d = SECS_PER_MIN;
         DSEL_MIN:  d = MINS_PER_HOUR;
         DSEL_HOUR: d = HOURS_PER_DAY;
         default:   d = HOURS_PER_DAY;
      endcase
      return d;
   endfunction

   function automatic logic [31:0] esd_recip(input esd_dsel_type dsel);
      logic [31:0] m;
      unique case (dsel)
         DSEL_SEC:  m = RECIP_60;
         DSEL_MIN:  m = RECIP_60;
         DSEL_HOUR: m = RECIP_24;
         default:   m = RECIP_24;
      endcase
      return m;
   endfunction

   // microprogram: three constant divisions, then the year and month walks
   function automatic esd_uword_type esd_ucode(input logic [PC_W-1:0] pc);
      esd_uword_type w;
      unique case (pc)
         4'd0:    w = '{op: OP_MUL,   dsel: DSEL_SEC,  target: 4'd0};
         4'd1:    w = '{op: OP_REM,   dsel: DSEL_SEC,  target: 4'd0};
         4'd2:    w = '{op: OP_FIX,   dsel: DSEL_SEC,  target: 4'd0};
         4'd3:    w = '{op: OP_MUL,   dsel: DSEL_MIN,  target: 4'd0};
         4'd4:    w = '{op: OP_REM,   dsel: DSEL_MIN,  target: 4'd0};
         4'd5:    w = '{op: OP_FIX,   dsel: DSEL_MIN,  target: 4'd0};
         4'd6:    w = '{op: OP_MUL,   dsel: DSEL_HOUR, target: 4'd0};
         4'd7:    w = '{op: OP_REM,   dsel: DSEL_HOUR, target: 4'd0};
         4'd8:    w = '{op: OP_FIX,   dsel: DSEL_HOUR, target: 4'd0};
         4'd9:    w = '{op: OP_YEAR,  dsel: DSEL_SEC,  target: 4'd9};
         4'd10:   w = '{op: OP_MONTH, dsel: DSEL_SEC,  target: 4'd10};
         default: w = '{op: OP_DONE,  dsel: DSEL_SEC,  target: 4'd0};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== design/epoch_seconds_to_date_unit.sv =====
`default_nettype none
//  channel   ports                      handshake
//  request   req_epoch_seconds          accepted when start is high and busy is low
//  result    rsp_* fields               rsp_valid high for one cycle, cannot be held off
//
//  one transaction runs the three constant divisions, then subtracts whole
//  years and then whole months from the day count; the year walk is the
//  longest part of a transaction
//  busy rises the cycle after start is taken and falls as rsp_valid rises,
//  so the next start may be taken while a result is shown
//  synchronous reset clears the sequencer and the result strobe
module epoch_seconds_to_date_unit
   import esd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [31:0] req_epoch_seconds,
   output logic             rsp_valid,
   output logic [5:0]       rsp_second_of_minute,
   output logic [5:0]       rsp_minute_of_hour,
   output logic [4:0]       rsp_hour_of_day,
   output logic [4:0]       rsp_day_of_month,
   output logic [3:0]       rsp_month_of_year,
   output logic [11:0]      rsp_calendar_year
);

   logic            busy_ff, busy_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   logic [31:0]     x_ff, x_in;
   logic [31:0]     q_ff, q_in;
   logic [6:0]      r_ff, r_in;
   logic [5:0]      sec_ff, sec_in;
   logic [5:0]      min_ff, min_in;
   logic [4:0]      hour_ff, hour_in;
   logic [3:0]      month_ff, month_in;
   logic [11:0]     year_ff, year_in;

   esd_uword_type   uw;
   logic [6:0]      divisor;
   logic [63:0]     product;
   logic [31:0]     rem_full;
   logic            rem_ge;
   logic [6:0]      r_fix;
   logic [31:0]     q_fix;
   logic            leap;
   logic [8:0]      year_len;
   logic [4:0]      month_len;

   // control word fetch and shared datapath terms
   always_comb begin
      uw        = esd_ucode(pc_ff);
      divisor   = esd_divisor(uw.dsel);
      product   = {32'd0, x_ff} * {32'd0, esd_recip(uw.dsel)};
      rem_full  = x_ff - (q_ff * {25'd0, divisor});
      rem_ge    = (r_ff >= divisor);
      r_fix     = rem_ge ? (r_ff - divisor) : r_ff;
      q_fix     = rem_ge ? (q_ff + 32'd1) : q_ff;
      leap      = esd_is_leap(year_ff);
      year_len  = leap ? DAYS_LEAP : DAYS_COMMON;
      month_len = esd_month_len(month_ff, leap);
   end

   // sequencer and datapath next values
   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = 1'b0;
      pc_in        = pc_ff;
      x_in         = x_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      sec_in       = sec_ff;
      min_in       = min_ff;
      hour_in      = hour_ff;
      month_in     = month_ff;
      year_in      = year_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in  = 1'b1;
            pc_in    = '0;
            x_in     = req_epoch_seconds;
            year_in  = EPOCH_YEAR;
            month_in = 4'd0;
         end
      end else begin
         unique case (uw.op)
            OP_MUL: begin
               q_in  = product[63:32];
               pc_in = pc_ff + 1'b1;
            end
            OP_REM: begin
               r_in  = rem_full[6:0];
               pc_in = pc_ff + 1'b1;
            end
            OP_FIX: begin
               x_in  = q_fix;
               pc_in = pc_ff + 1'b1;
               unique case (uw.dsel)
                  DSEL_SEC:  sec_in  = r_fix[5:0];
                  DSEL_MIN:  min_in  = r_fix[5:0];
                  DSEL_HOUR: hour_in = r_fix[4:0];
                  default:   hour_in = r_fix[4:0];
               endcase
            end
            OP_YEAR: begin
               // stay on this step while a whole year remains
               if (x_ff >= {23'd0, year_len}) begin
                  x_in    = x_ff - {23'd0, year_len};
                  year_in = year_ff + 12'd1;
                  pc_in   = uw.target;
               end else begin
                  pc_in = pc_ff + 1'b1;
               end
            end
            OP_MONTH: begin
               // december absorbs whatever is left
               if ((x_ff >= {27'd0, month_len}) && (month_ff < LAST_MONTH)) begin
                  x_in     = x_ff - {27'd0, month_len};
                  month_in = month_ff + 4'd1;
                  pc_in    = uw.target;
               end else begin
                  pc_in = pc_ff + 1'b1;
               end
            end
            OP_DONE: begin
               busy_in      = 1'b0;
               rsp_valid_in = 1'b1;
               pc_in        = '0;
            end
            default: begin
               busy_in = 1'b0;
               pc_in   = '0;
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         pc_ff        <= pc_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      q_ff     <= q_in;
      r_ff     <= r_in;
      sec_ff   <= sec_in;
      min_ff   <= min_in;
      hour_ff  <= hour_in;
      month_ff <= month_in;
      year_ff  <= year_in;
   end

   // result ports
   assign busy                 = busy_ff;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_second_of_minute = sec_ff;
   assign rsp_minute_of_hour   = min_ff;
   assign rsp_hour_of_day      = hour_ff;
   assign rsp_day_of_month     = x_ff[4:0] + 5'd1;
   assign rsp_month_of_year    = month_ff + 4'd1;
   assign rsp_calendar_year    = year_ff;

endmodule

`default_nettype wire

// ===== design/esd_checker.sv =====
`default_nettype none

module esd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic [5:0]  rsp_second_of_minute,
   input wire logic [5:0]  rsp_minute_of_hour,
   input wire logic [4:0]  rsp_hour_of_day,
   input wire logic [4:0]  rsp_day_of_month,
   input wire logic [3:0]  rsp_month_of_year
);

   // a taken transaction keeps the unit busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after start");

   // the unit goes idle only by delivering a result
   a_done_result: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_valid)
      else $error("busy fell without a result");

   // a result never overlaps work on the next transaction
   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && !$past(rsp_valid)))
      else $error("result strobe while busy or repeated");

   // delivered fields stay inside their calendar ranges
   a_fields_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_second_of_minute < 6'd60) && (rsp_minute_of_hour < 6'd60)
                     && (rsp_hour_of_day < 5'd24) && (rsp_day_of_month != 5'd0)
                     && (rsp_month_of_year != 4'd0) && (rsp_month_of_year < 4'd13)))
      else $error("result field out of range");

endmodule

bind epoch_seconds_to_date_unit esd_checker u_esd_checker (
   .clock                (clock),
   .reset                (reset),
   .start                (start),
   .busy                 (busy),
   .rsp_valid            (rsp_valid),
   .rsp_second_of_minute (rsp_second_of_minute),
   .rsp_minute_of_hour   (rsp_minute_of_hour),
   .rsp_hour_of_day      (rsp_hour_of_day),
   .rsp_day_of_month     (rsp_day_of_month),
   .rsp_month_of_year    (rsp_month_of_year)
);

`default_nettype wire

// ===== tb/epoch_seconds_to_date_unit_tb.sv =====
`default_nettype none

module epoch_seconds_to_date_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned FIRST_YEAR     = 1970;
   localparam int unsigned LAST_FULL_YEAR = 2105;
   localparam int unsigned SECS_IN_MINUTE = 60;
   localparam int unsigned MINS_IN_HOUR   = 60;
   localparam int unsigned HOURS_IN_DAY   = 24;
   localparam int unsigned FEBRUARY       = 2;
   localparam int unsigned DECEMBER       = 12;
   localparam int unsigned LAST_EPOCH     = 32'hFFFF_FFFF;
   localparam int          RANDOM_PER_PHASE = 200;
   localparam int          MAX_GAP        = 12;
   localparam int          DRAIN_CYCLES   = 200;
   localparam int          CYCLE_LIMIT    = 600_000;
   localparam int          MAX_PRINTED    = 20;

   // one broken-down date, tagged with the epoch it came from
   typedef struct {
      logic [31:0] epoch;
      logic [5:0]  sec;
      logic [5:0]  min;
      logic [4:0]  hour;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [11:0] year;
   } date_record_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [31:0] req_epoch_seconds = '0;
   logic        busy;
   logic        rsp_valid;
   logic [5:0]  rsp_second_of_minute;
   logic [5:0]  rsp_minute_of_hour;
   logic [4:0]  rsp_hour_of_day;
   logic [4:0]  rsp_day_of_month;
   logic [3:0]  rsp_month_of_year;
   logic [11:0] rsp_calendar_year;

   date_record_type pending_dates[$];
   int           sender_idle_pct = 0;
   int           accepted_count  = 0;
   int           dates_checked   = 0;
   int           mismatch_count  = 0;
   int           cycle_count     = 0;

   always #4 clock = ~clock;

   epoch_seconds_to_date_unit DUT (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_epoch_seconds    (req_epoch_seconds),
      .rsp_valid            (rsp_valid),
      .rsp_second_of_minute (rsp_second_of_minute),
      .rsp_minute_of_hour   (rsp_minute_of_hour),
      .rsp_hour_of_day      (rsp_hour_of_day),
      .rsp_day_of_month     (rsp_day_of_month),
      .rsp_month_of_year    (rsp_month_of_year),
      .rsp_calendar_year    (rsp_calendar_year)
   );

   // gregorian leap rule
   function automatic bit leap_year(input int unsigned yr);
      return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
   endfunction

   function automatic int unsigned year_length(input int unsigned yr);
      return leap_year(yr) ? 366 : 365;
   endfunction

   // month is 1..12
   function automatic int unsigned month_length(input int unsigned mo, input int unsigned yr);
      case (mo)
         FEBRUARY:       return leap_year(yr) ? 29 : 28;
         4, 6, 9, 11:    return 30;
         default:        return 31;
      endcase
   endfunction

   // expected calendar fields for one epoch value
   function automatic date_record_type break_down_epoch(input logic [31:0] secs);
      date_record_type d;
      int unsigned  t;
      int unsigned  days;
      int unsigned  yr;
      int unsigned  mo;
      t       = secs;
      d.epoch = secs;
      d.sec   = 6'(t % SECS_IN_MINUTE);
      t       = t / SECS_IN_MINUTE;
      d.min   = 6'(t % MINS_IN_HOUR);
      t       = t / MINS_IN_HOUR;
      d.hour  = 5'(t % HOURS_IN_DAY);
      days    = t / HOURS_IN_DAY;
      // year walk against each year's own length
      yr = FIRST_YEAR;
      while (days >= year_length(yr)) begin
         days -= year_length(yr);
         yr++;
      end
      // month walk, february already sized for the year
      mo = 1;
      while (mo < DECEMBER && days >= month_length(mo, yr)) begin
         days -= month_length(mo, yr);
         mo++;
      end
      d.day   = 5'(days + 1);
      d.month = 4'(mo);
      d.year  = 12'(yr);
      return d;
   endfunction

   // epoch value of a calendar date and time, for stimulus
   function automatic logic [31:0] epoch_of(input int unsigned yr, input int unsigned mo,
                                            input int unsigned dy, input int unsigned hh,
                                            input int unsigned mm, input int unsigned ss);
      longint unsigned total;
      int unsigned     y;
      int unsigned     m;
      total = 0;
      for (y = FIRST_YEAR; y < yr; y++) total += year_length(y);
      for (m = 1; m < mo; m++) total += month_length(m, yr);
      total += dy - 1;
      total = ((total * HOURS_IN_DAY + hh) * MINS_IN_HOUR + mm) * SECS_IN_MINUTE + ss;
      return total[31:0];
   endfunction

   // random epoch: uniform, month/year boundaries, or the top of the range
   function automatic logic [31:0] pick_random_epoch();
      int unsigned yr;
      int unsigned mo;
      case ($urandom_range(3))
         2: begin
            if ($urandom_range(3) == 0) begin
               case ($urandom_range(3))
                  0:       yr = 1972;
                  1:       yr = 2000;
                  2:       yr = 2100;
                  default: yr = 2104;
               endcase
            end else begin
               yr = $urandom_range(LAST_FULL_YEAR, FIRST_YEAR);
            end
            mo = $urandom_range(DECEMBER, 1);
            if ($urandom_range(1) == 1)
               return epoch_of(yr, mo, month_length(mo, yr), 23, 59, 59);
            else
               return epoch_of(yr, mo, 1, 0, 0, 0);
         end
         3:       return $urandom_range(LAST_EPOCH, LAST_EPOCH - 32'd40_000_000);
         default: return $urandom;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_PRINTED) $display("mismatch: %s", msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want, input logic [31:0] secs);
      if (got !== want)
         report_mismatch($sformatf("%s for epoch %0d: got %0d, expected %0d",
                                   name, secs, got, want));
   endtask

   // cycle limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_dates.size());
         $display("[epoch_seconds_to_date_unit] ERROR");
         $finish;
      end
   end

   // record the expected date of every accepted transaction
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         pending_dates.push_back(break_down_epoch(req_epoch_seconds));
         accepted_count++;
      end
   end

   // compare each result with the oldest expected date
   always @(posedge clock) begin : result_check
      date_record_type want;
      if (!reset && rsp_valid) begin
         if (pending_dates.size() == 0) begin
            report_mismatch("result with no transaction pending");
         end else begin
            want = pending_dates.pop_front();
            check_field("second", 32'(rsp_second_of_minute), 32'(want.sec),   want.epoch);
            check_field("minute", 32'(rsp_minute_of_hour),   32'(want.min),   want.epoch);
            check_field("hour",   32'(rsp_hour_of_day),      32'(want.hour),  want.epoch);
            check_field("day",    32'(rsp_day_of_month),     32'(want.day),   want.epoch);
            check_field("month",  32'(rsp_month_of_year),    32'(want.month), want.epoch);
            check_field("year",   32'(rsp_calendar_year),    32'(want.year),  want.epoch);
            dates_checked++;
         end
      end
   end

   // one transaction: optional gap with junk data, then hold start until taken
   task automatic send_epoch(input logic [31:0] secs);
      int gap;
      if ($urandom_range(99) < sender_idle_pct) begin
         gap = $urandom_range(MAX_GAP, 1);
         repeat (gap) begin
            @(negedge clock);
            start             <= 1'b0;
            req_epoch_seconds <= $urandom;
         end
      end
      @(negedge clock);
      start             <= 1'b1;
      req_epoch_seconds <= secs;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // all-zero, all-one and alternating bit patterns, sign boundary
   task automatic test_input_extremes();
      logic [31:0] patterns[6];
      patterns = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555};
      foreach (patterns[i]) send_epoch(patterns[i]);
   endtask

   // second, minute, hour and day rollovers from the start of the epoch
   task automatic test_time_of_day_edges();
      send_epoch(32'd59);
      send_epoch(32'd60);
      send_epoch(32'd3599);
      send_epoch(32'd3600);
      send_epoch(32'd86399);
      send_epoch(32'd86400);
   endtask

   // leap days, last day of leap and common years, the 2100 exception
   task automatic test_calendar_edges();
      send_epoch(epoch_of(1970, 12, 31, 23, 59, 59));
      send_epoch(epoch_of(1972,  2, 28, 23, 59, 59));
      send_epoch(epoch_of(1972,  2, 29, 12,  0,  0));
      send_epoch(epoch_of(1972,  3,  1,  0,  0,  0));
      send_epoch(epoch_of(1972, 12, 31, 23, 59, 59));
      send_epoch(epoch_of(1973,  1,  1,  0,  0,  0));
      send_epoch(epoch_of(2000,  2, 29,  0,  0,  0));
      send_epoch(epoch_of(2100,  2, 28, 23, 59, 59));
      send_epoch(epoch_of(2100,  3,  1,  0,  0,  0));
      send_epoch(epoch_of(2105, 12, 31, 23, 59, 59));
   endtask

   task automatic test_random_phase(input int idle_pct, input int count);
      sender_idle_pct = idle_pct;
      repeat (count) send_epoch(pick_random_epoch());
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_input_extremes();
      test_time_of_day_edges();
      test_calendar_edges();
      test_random_phase(38, RANDOM_PER_PHASE);
      test_random_phase(71, RANDOM_PER_PHASE);
      test_random_phase(0,  RANDOM_PER_PHASE);

      @(negedge clock);
      start <= 1'b0;
      while (pending_dates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d transactions, %0d dates checked: bit extremes, time-of-day rollovers,",
               accepted_count, dates_checked);
      $display("leap days and year ends, random epochs with 38/71/0 percent input gaps");
      if (mismatch_count == 0)
         $display("[epoch_seconds_to_date_unit] OK");
      else
         $display("[epoch_seconds_to_date_unit] ERROR");
      $finish;
   end

endmodule

`default_nettype wire
